### rtl/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg
// Shared constants and types of the longest-path / cycle-check block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlp_pkg;

  // node ids are six bits wide, so the graph has 64 slots
  localparam int NODE_W      = 6;
  localparam int NODE_SLOTS  = 64;
  localparam int MAX_NODES_DEF = 64;

  // item opcodes
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // walk engine requests toward the graph store
  typedef struct packed {
    logic              edge_en;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
    logic              rd_en;
    logic [NODE_W-1:0] rd_node;
    logic              clear;
  } store_ctrl_t;

  // graph store answers
  typedef struct packed {
    logic [NODE_SLOTS-1:0] row;
    logic [NODE_W-1:0]     highest;
    logic                  wr_busy;
  } store_stat_t;

endpackage

`default_nettype wire

### rtl/dlp_if.sv
// ----------------------------------------------------------------------------
// dlp channel interfaces
// Valid/ready channels for edge/evaluate items and for results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dlp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [5:0] edge_from;
  logic [5:0] edge_to;

  modport source (output valid, opcode, edge_from, edge_to, input ready);
  modport sink   (input valid, opcode, edge_from, edge_to, output ready);
endinterface

interface dlp_out_if;
  logic       valid;
  logic       ready;
  logic       cycle_error;
  logic [5:0] path_nodes;

  modport source (output valid, cycle_error, path_nodes, input ready);
  modport sink   (input valid, cycle_error, path_nodes, output ready);
endinterface

`default_nettype wire

### rtl/dag_longest_path_with_cycle_check.sv
// ----------------------------------------------------------------------------
// dag_longest_path_with_cycle_check
// Longest path in a directed graph with a directed-cycle check.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per item. opcode 0 adds edge edge_from -> edge_to
//   (ignored if either end is 0); such beats are taken one per cycle and give
//   no result. opcode 1 evaluates the loaded graph, returns one out_ch beat
//   (cycle_error, path_nodes) and empties the graph store.
//   Evaluation runs a depth-first walk on the adjacency memory. The time to
//   the result beat depends on the ids up to the highest, the distinct edges
//   among them and the walk roots, and a cycle ends the walk early. The walk
//   is paced by the single read port of the adjacency memory and the
//   registered reads of the walk stack and path-length memories.
//   in_ch is not ready during an evaluation, nor while a result waits in
//   the output register and out_ch.ready is low. Edge beats are otherwise
//   taken back to back.
//   Reset empties the graph at once through per-row valid flags; no
//   clearing pass is needed, and the block is ready once reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dag_longest_path_with_cycle_check #(
  parameter int MAX_NODES = dlp_pkg::MAX_NODES_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  dlp_in_if.sink   in_ch,
  dlp_out_if.source out_ch
);
  import dlp_pkg::*;

  store_ctrl_t ctrl;
  store_stat_t stat;
  logic        in_fire;

  assign in_fire = in_ch.valid && in_ch.ready;

  dlp_graph_store #(.MAX_NODES(MAX_NODES)) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  dlp_dfs_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_opcode       (in_ch.opcode),
    .in_edge_from    (in_ch.edge_from),
    .in_edge_to      (in_ch.edge_to),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cycle_error (out_ch.cycle_error),
    .out_path_nodes  (out_ch.path_nodes),
    .ctrl            (ctrl),
    .stat            (stat)
  );

  // an evaluate beat keeps the input closed in the next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.opcode == OP_EVAL) |=> !in_ch.ready)
    else $error("input open right after evaluate beat");

  // a cycle report carries no path length
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.cycle_error) |-> (out_ch.path_nodes == '0))
    else $error("path length on cycle report");

  // a clean result counts at least one node
  a_path_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.cycle_error) |-> (out_ch.path_nodes != '0))
    else $error("empty path on clean result");

  // no result beat comes out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result beat after reset");

endmodule

`default_nettype wire

### rtl/dlp_graph_store.sv
// ----------------------------------------------------------------------------
// dlp_graph_store
// Adjacency bit matrix in a synchronous memory with per-row valid flags,
// read-modify-write edge insertion with forwarding, highest id tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlp_graph_store #(
  parameter int MAX_NODES = dlp_pkg::MAX_NODES_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire dlp_pkg::store_ctrl_t ctrl,
  output dlp_pkg::store_stat_t      stat
);
  import dlp_pkg::*;

  logic [NODE_SLOTS-1:0] adj_mem [NODE_SLOTS];
  logic [NODE_SLOTS-1:0] rd_data_r;
  logic [NODE_W-1:0]     rd_addr_r;
  logic [NODE_SLOTS-1:0] row_valid_r;
  logic [NODE_W-1:0]     highest_r;

  logic                  pend_r;
  logic [NODE_W-1:0]     pend_row_r;
  logic [NODE_W-1:0]     pend_bit_r;
  logic                  fwd_r;
  logic [NODE_W-1:0]     fwd_row_r;
  logic [NODE_SLOTS-1:0] fwd_data_r;

  logic                  edge_ok;
  logic [NODE_W-1:0]     rd_addr;
  logic [NODE_SLOTS-1:0] base_row;
  logic [NODE_SLOTS-1:0] wr_row;

  // edge filter: zero endpoints and ids beyond the node limit are dropped
  assign edge_ok = ctrl.edge_en && (ctrl.edge_from != '0) && (ctrl.edge_to != '0)
                   && (int'(ctrl.edge_from) < MAX_NODES) && (int'(ctrl.edge_to) < MAX_NODES);

  assign rd_addr = ctrl.edge_en ? ctrl.edge_from : ctrl.rd_node;

  // memory read port
  always_ff @(posedge clk) begin
    if (ctrl.edge_en || ctrl.rd_en) begin
      rd_data_r <= adj_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // merge base row: forward the write of the previous cycle on a row match
  always_comb begin
    if (fwd_r && (fwd_row_r == pend_row_r)) begin
      base_row = fwd_data_r;
    end else if (row_valid_r[pend_row_r]) begin
      base_row = rd_data_r;
    end else begin
      base_row = '0;
    end
    wr_row = base_row | (NODE_SLOTS'(1) << pend_bit_r);
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (pend_r) begin
      adj_mem[pend_row_r] <= wr_row;
    end
  end

  // pending write and forwarding registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      pend_r <= edge_ok;
      fwd_r  <= pend_r;
    end
    if (edge_ok) begin
      pend_row_r <= ctrl.edge_from;
      pend_bit_r <= ctrl.edge_to;
    end
    if (pend_r) begin
      fwd_row_r  <= pend_row_r;
      fwd_data_r <= wr_row;
    end
  end

  // row valid flags and highest node id
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      row_valid_r <= '0;
      highest_r   <= '0;
    end else begin
      if (pend_r) begin
        row_valid_r[pend_row_r] <= 1'b1;
      end
      if (edge_ok) begin
        if (ctrl.edge_from > highest_r && ctrl.edge_from >= ctrl.edge_to) begin
          highest_r <= ctrl.edge_from;
        end else if (ctrl.edge_to > highest_r) begin
          highest_r <= ctrl.edge_to;
        end
      end
    end
  end

  assign stat.row     = row_valid_r[rd_addr_r] ? rd_data_r : '0;
  assign stat.highest = highest_r;
  assign stat.wr_busy = pend_r;

endmodule

`default_nettype wire

### rtl/dlp_dfs_engine.sv
// ----------------------------------------------------------------------------
// dlp_dfs_engine
// Depth-first walk sequencer with walk stack and longest-path memories,
// item intake and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlp_dfs_engine (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_fire,
  input  wire                          in_opcode,
  input  wire [dlp_pkg::NODE_W-1:0]    in_edge_from,
  input  wire [dlp_pkg::NODE_W-1:0]    in_edge_to,
  output logic                         in_ready,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_cycle_error,
  output logic [dlp_pkg::NODE_W-1:0]   out_path_nodes,
  output dlp_pkg::store_ctrl_t         ctrl,
  input  wire dlp_pkg::store_stat_t    stat
);
  import dlp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_OUTER = 9'b000000010,
    S_ROW   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_PWAIT = 9'b000010000,
    S_PLONG = 9'b000100000,
    S_LWAIT = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_CYC   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [2*NODE_W-1:0] stack_mem [NODE_SLOTS];
  logic [NODE_W-1:0]   lf_mem    [NODE_SLOTS];
  logic [2*NODE_W-1:0] stack_rd_r;
  logic [NODE_W-1:0]   lf_rd_r;

  logic [NODE_SLOTS-1:0] visited_r, on_stack_r;
  logic [NODE_W:0]       outer_r, outer_nxt;
  logic [NODE_W:0]       sp_r, sp_nxt;
  logic [NODE_W-1:0]     top_node_r, top_node_nxt;
  logic [NODE_W-1:0]     top_last_r, top_last_nxt;
  logic [NODE_W-1:0]     top_long_r, top_long_nxt;
  logic [NODE_W-1:0]     child_long_r, child_long_nxt;
  logic [NODE_W-1:0]     best_r, best_nxt;
  logic [NODE_SLOTS-1:0] row_r, row_nxt;
  logic                  out_valid_r;
  logic                  out_err_r;
  logic [NODE_W-1:0]     out_path_r;

  logic [NODE_W-1:0] nbr;
  logic [NODE_W:0]   cand;
  logic              stack_we, stack_re, lf_we, lf_re;
  logic [NODE_W-1:0] stack_waddr, stack_raddr, lf_waddr, lf_raddr, lf_wdata;
  logic              mark_set, mark_pop, marks_clear;
  logic [NODE_W-1:0] mark_node;
  logic              result_load;

  // lowest neighbor above the last one examined, zero when none
  function automatic logic [NODE_W-1:0] next_nbr(input logic [NODE_SLOTS-1:0] row,
                                                 input logic [NODE_W-1:0] last);
    logic [NODE_SLOTS-1:0] m;
    logic [NODE_W-1:0]     res;
    m   = row & ~((NODE_SLOTS'(2) << last) - NODE_SLOTS'(1));
    res = '0;
    for (int j = NODE_SLOTS - 1; j >= 1; j--) begin
      if (m[j]) res = NODE_W'(j);
    end
    return res;
  endfunction

  assign nbr = next_nbr(row_r, top_last_r);

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= {top_node_r, nbr};
    if (stack_re) stack_rd_r <= stack_mem[stack_raddr];
  end

  // longest-path memory
  always_ff @(posedge clk) begin
    if (lf_we) lf_mem[lf_waddr] <= lf_wdata;
    if (lf_re) lf_rd_r <= lf_mem[lf_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    outer_nxt      = outer_r;
    sp_nxt         = sp_r;
    top_node_nxt   = top_node_r;
    top_last_nxt   = top_last_r;
    top_long_nxt   = top_long_r;
    child_long_nxt = child_long_r;
    best_nxt       = best_r;
    row_nxt        = row_r;
    stack_we = 1'b0; stack_re = 1'b0; lf_we = 1'b0; lf_re = 1'b0;
    stack_waddr = sp_r[NODE_W-1:0] - NODE_W'(1);
    stack_raddr = sp_r[NODE_W-1:0] - NODE_W'(2);
    lf_waddr = top_node_r;
    lf_wdata = top_long_r;
    lf_raddr = nbr;
    mark_set = 1'b0; mark_pop = 1'b0; marks_clear = 1'b0;
    mark_node = nbr;
    result_load = 1'b0;
    cand = '0;
    ctrl.edge_en   = 1'b0;
    ctrl.edge_from = in_edge_from;
    ctrl.edge_to   = in_edge_to;
    ctrl.rd_en     = 1'b0;
    ctrl.rd_node   = nbr;
    ctrl.clear     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_opcode == OP_EVAL) begin
            outer_nxt = (NODE_W+1)'(1);
            best_nxt  = '0;
            state_nxt = S_OUTER;
          end else begin
            ctrl.edge_en = 1'b1;
          end
        end
      end
      // pick the next unvisited start node
      S_OUTER: begin
        if (!stat.wr_busy) begin
          if (outer_r[NODE_W] || (outer_r[NODE_W-1:0] > stat.highest)) begin
            state_nxt = S_DONE;
          end else if (visited_r[outer_r[NODE_W-1:0]]) begin
            outer_nxt = outer_r + (NODE_W+1)'(1);
          end else begin
            mark_set      = 1'b1;
            mark_node     = outer_r[NODE_W-1:0];
            top_node_nxt  = outer_r[NODE_W-1:0];
            top_last_nxt  = '0;
            top_long_nxt  = '0;
            sp_nxt        = (NODE_W+1)'(1);
            ctrl.rd_en    = 1'b1;
            ctrl.rd_node  = outer_r[NODE_W-1:0];
            state_nxt     = S_ROW;
          end
        end
      end
      S_ROW: begin
        row_nxt   = stat.row;
        state_nxt = S_SCAN;
      end
      // examine one neighbor of the top node, or pop the node when it has none left
      S_SCAN: begin
        if (nbr == '0) begin
          mark_pop  = 1'b1;
          mark_node = top_node_r;
          lf_we     = 1'b1;
          if (top_long_r > best_r) best_nxt = top_long_r;
          if (sp_r == (NODE_W+1)'(1)) begin
            outer_nxt = outer_r + (NODE_W+1)'(1);
            state_nxt = S_OUTER;
          end else begin
            sp_nxt         = sp_r - (NODE_W+1)'(1);
            stack_re       = 1'b1;
            child_long_nxt = top_long_r;
            state_nxt      = S_PWAIT;
          end
        end else begin
          top_last_nxt = nbr;
          if (!visited_r[nbr]) begin
            if (!sp_r[NODE_W]) begin
              stack_we     = 1'b1;
              lf_we        = 1'b1;
              mark_set     = 1'b1;
              top_node_nxt = nbr;
              top_last_nxt = '0;
              top_long_nxt = '0;
              sp_nxt       = sp_r + (NODE_W+1)'(1);
              ctrl.rd_en   = 1'b1;
              state_nxt    = S_ROW;
            end
          end else if (on_stack_r[nbr]) begin
            state_nxt = S_CYC;
          end else begin
            lf_re     = 1'b1;
            state_nxt = S_LWAIT;
          end
        end
      end
      // parent entry back from the stack: fetch its length and row
      S_PWAIT: begin
        top_node_nxt = stack_rd_r[2*NODE_W-1:NODE_W];
        top_last_nxt = stack_rd_r[NODE_W-1:0];
        lf_re        = 1'b1;
        lf_raddr     = stack_rd_r[2*NODE_W-1:NODE_W];
        ctrl.rd_en   = 1'b1;
        ctrl.rd_node = stack_rd_r[2*NODE_W-1:NODE_W];
        state_nxt    = S_PLONG;
      end
      S_PLONG: begin
        cand = {1'b0, child_long_r} + (NODE_W+1)'(1);
        top_long_nxt = (cand > {1'b0, lf_rd_r}) ? cand[NODE_W-1:0] : lf_rd_r;
        row_nxt      = stat.row;
        state_nxt    = S_SCAN;
      end
      // finished neighbor: take its length plus one
      S_LWAIT: begin
        cand = {1'b0, lf_rd_r} + (NODE_W+1)'(1);
        if (cand > {1'b0, top_long_r}) top_long_nxt = cand[NODE_W-1:0];
        state_nxt = S_SCAN;
      end
      S_DONE, S_CYC: begin
        result_load = 1'b1;
        marks_clear = 1'b1;
        ctrl.clear  = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      outer_r <= '0;
      sp_r    <= '0;
      best_r  <= '0;
    end else begin
      state_r <= state_nxt;
      outer_r <= outer_nxt;
      sp_r    <= sp_nxt;
      best_r  <= best_nxt;
    end
    top_node_r   <= top_node_nxt;
    top_last_r   <= top_last_nxt;
    top_long_r   <= top_long_nxt;
    child_long_r <= child_long_nxt;
    row_r        <= row_nxt;
  end

  // visited and on-stack marks
  always_ff @(posedge clk) begin
    if (!rst_n || marks_clear) begin
      visited_r  <= '0;
      on_stack_r <= '0;
    end else if (mark_set) begin
      visited_r[mark_node]  <= 1'b1;
      on_stack_r[mark_node] <= 1'b1;
    end else if (mark_pop) begin
      on_stack_r[mark_node] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (result_load) begin
      out_err_r  <= (state_r == S_CYC);
      out_path_r <= (state_r == S_CYC) ? '0 : best_r + NODE_W'(1);
    end
  end

  assign in_ready        = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_cycle_error = out_err_r;
  assign out_path_nodes  = out_path_r;

endmodule

`default_nettype wire

### tb/dag_longest_path_with_cycle_check_test.sv
// ----------------------------------------------------------------------------
// dag_longest_path_with_cycle_check_test
// Loads random and directed edge sets, evaluates them, and compares the cycle
// flag and longest-path node count against a behavioral depth-first walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dag_longest_path_with_cycle_check_test;
  import dlp_pkg::*;

  typedef struct packed {
    logic       opcode;
    logic [5:0] edge_from;
    logic [5:0] edge_to;
  } graph_beat_t;

  typedef struct packed {
    logic       cycle_error;
    logic [5:0] path_nodes;
  } path_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dlp_in_if  in_ch ();
  dlp_out_if out_ch ();

  dag_longest_path_with_cycle_check u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // shadow graph of the predictor
  logic [63:0] graph_rows [64];
  logic [5:0]  graph_top;
  logic        seen_mark [64];
  logic        open_mark [64];
  logic [5:0]  depth_from [64];
  logic [5:0]  trail_node [64];
  logic [5:0]  trail_last [64];

  graph_beat_t  pending_beats [$];
  path_result_t expected_paths [$];
  int           error_count = 0;
  int           cycle_count = 0;
  bit           noisy_tx = 1'b1;
  bit           noisy_rx = 1'b1;
  int           rx_hold = 0;
  bit           sender_pause = 1'b0;
  bit           paused_once = 1'b0;

  function automatic void clear_graph();
    for (int i = 0; i < 64; i++) begin
      graph_rows[i] = '0;
      seen_mark[i]  = 1'b0;
      open_mark[i]  = 1'b0;
      depth_from[i] = '0;
    end
    graph_top = '0;
  endfunction

  function automatic logic [5:0] lowest_above(logic [63:0] row, logic [5:0] last);
    for (int j = 1; j < 64; j++)
      if (j > last && row[j]) return 6'(j);
    return '0;
  endfunction

  // iterative dfs from one root; returns 1 on a cycle
  function automatic bit walk_root(logic [5:0] root);
    int          sp;
    logic [5:0]  node;
    logic [5:0]  nxt;
    logic [5:0]  up;
    sp = 1;
    seen_mark[root] = 1'b1;
    open_mark[root] = 1'b1;
    depth_from[root] = '0;
    trail_node[0] = root;
    trail_last[0] = '0;
    while (sp > 0) begin
      node = trail_node[sp-1];
      nxt  = lowest_above(graph_rows[node], trail_last[sp-1]);
      if (nxt == 0) begin
        open_mark[node] = 1'b0;
        sp--;
        if (sp > 0) begin
          up = trail_node[sp-1];
          if (7'(depth_from[node]) + 7'd1 > 7'(depth_from[up]))
            depth_from[up] = depth_from[node] + 6'd1;
        end
      end else begin
        trail_last[sp-1] = nxt;
        if (!seen_mark[nxt]) begin
          if (sp < 64) begin
            seen_mark[nxt] = 1'b1;
            open_mark[nxt] = 1'b1;
            depth_from[nxt] = '0;
            trail_node[sp] = nxt;
            trail_last[sp] = '0;
            sp++;
          end
        end else if (open_mark[nxt]) begin
          return 1'b1;
        end else if (7'(depth_from[nxt]) + 7'd1 > 7'(depth_from[node])) begin
          depth_from[node] = depth_from[nxt] + 6'd1;
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one accepted beat to the shadow graph
  function automatic void predict_path(graph_beat_t b);
    path_result_t r;
    bit           loop_found;
    logic [5:0]   best;
    loop_found = 1'b0;
    best = '0;
    if (b.opcode == OP_EDGE) begin
      if (b.edge_from != 0 && b.edge_to != 0) begin
        graph_rows[b.edge_from][b.edge_to] = 1'b1;
        if (b.edge_from > graph_top) graph_top = b.edge_from;
        if (b.edge_to > graph_top) graph_top = b.edge_to;
      end
      return;
    end
    for (int i = 1; i <= graph_top; i++)
      if (!loop_found && !seen_mark[i] && walk_root(6'(i))) loop_found = 1'b1;
    if (!loop_found)
      for (int i = 1; i <= graph_top; i++)
        if (depth_from[i] > best) best = depth_from[i];
    r.cycle_error = loop_found;
    r.path_nodes  = loop_found ? 6'd0 : best + 6'd1;
    expected_paths = {expected_paths, r};
    clear_graph();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic graph_beat_t make_beat(logic op, int f, int t);
    graph_beat_t b;
    b.opcode = op;
    b.edge_from = 6'(f);
    b.edge_to = 6'(t);
    return b;
  endfunction

  // append one beat to the stimulus queue
  function automatic void queue_beat(graph_beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_path(in_ch.opcode ?
        make_beat(1'b1, in_ch.edge_from, in_ch.edge_to) :
        make_beat(1'b0, in_ch.edge_from, in_ch.edge_to));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() > 0 && !sender_pause &&
            !(noisy_tx && $urandom_range(99) < 30)) begin
          graph_beat_t b;
          b = pending_beats.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.opcode    <= b.opcode;
          in_ch.edge_from <= b.edge_from;
          in_ch.edge_to   <= b.edge_to;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_EDGE;
    in_ch.edge_from = '0;
    in_ch.edge_to = '0;
    out_ch.ready = 1'b0;
    clear_graph();
  end

  // receiver hold-off counter
  always @(posedge clk) begin
    if (rx_hold > 0) rx_hold <= rx_hold - 1;
  end

  // result monitor and receiver ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_paths.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          path_result_t w;
          w = expected_paths.pop_front();
          if (out_ch.cycle_error !== w.cycle_error)
            report_mismatch("cycle_error", out_ch.cycle_error, w.cycle_error);
          if (out_ch.path_nodes !== w.path_nodes)
            report_mismatch("path_nodes", out_ch.path_nodes, w.path_nodes);
        end
      end
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(noisy_rx && $urandom_range(99) < 30);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_graph(int kind);
    int n;
    int ne;
    int f;
    int t;
    n  = ($urandom_range(9) == 0) ? $urandom_range(63, 2) : $urandom_range(12, 2);
    ne = $urandom_range(2 * n);
    for (int k = 0; k < ne; k++) begin
      f = $urandom_range(n, 1);
      t = $urandom_range(n, 1);
      // acyclic most of the time: edges go from low to high id
      if (kind < 7) begin
        if (f == t) t = (f < 63) ? f + 1 : f - 1;
        if (f > t) begin
          int s;
          s = f; f = t; t = s;
        end
      end
      if ($urandom_range(19) == 0) f = 0;
      if ($urandom_range(19) == 0) t = 0;
      queue_beat(make_beat(OP_EDGE, f, t));
    end
    queue_beat(make_beat(OP_EVAL, $urandom_range(63), $urandom_range(63)));
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || in_ch.valid || expected_paths.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int sent;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, self-loop, zero endpoints, duplicates, a three-node cycle, chains through id 63
    queue_beat(make_beat(OP_EVAL, 63, 63));
    queue_beat(make_beat(OP_EDGE, 5, 5));
    queue_beat(make_beat(OP_EVAL, 0, 0));
    queue_beat(make_beat(OP_EDGE, 0, 7));
    queue_beat(make_beat(OP_EDGE, 7, 0));
    queue_beat(make_beat(OP_EVAL, 42, 21));
    queue_beat(make_beat(OP_EDGE, 1, 63));
    queue_beat(make_beat(OP_EDGE, 1, 63));
    queue_beat(make_beat(OP_EDGE, 63, 2));
    queue_beat(make_beat(OP_EDGE, 2, 3));
    queue_beat(make_beat(OP_EVAL, 0, 0));
    queue_beat(make_beat(OP_EDGE, 1, 2));
    queue_beat(make_beat(OP_EDGE, 2, 3));
    queue_beat(make_beat(OP_EDGE, 3, 1));
    queue_beat(make_beat(OP_EVAL, 0, 0));
    queue_beat(make_beat(OP_EDGE, 62, 63));
    queue_beat(make_beat(OP_EVAL, 0, 0));
    wait_drained();

    // full chain 1..63, path of all 63 nodes, with receiver holding off
    for (int i = 1; i < 63; i++) queue_beat(make_beat(OP_EDGE, i, i + 1));
    queue_beat(make_beat(OP_EVAL, 0, 0));
    queue_beat(make_beat(OP_EVAL, 0, 0));
    for (int i = 0; i < 20; i++) queue_beat(make_beat(OP_EDGE, i + 1, 63 - i));
    rx_hold = 400;
    queue_beat(make_beat(OP_EVAL, 0, 0));
    wait_drained();

    // random graphs; a quiet stretch, and a sender pause midway
    sent = 0;
    while (sent < 850) begin
      int queued_prior;
      queued_prior = pending_beats.size();
      if (sent > 300 && sent < 500) begin
        noisy_tx = 1'b0;
        noisy_rx = 1'b0;
      end else begin
        noisy_tx = 1'b1;
        noisy_rx = 1'b1;
      end
      add_graph($urandom_range(9));
      sent += pending_beats.size() - queued_prior;
      while (pending_beats.size() > 4) @(posedge clk);
      if (sent > 600 && !paused_once) begin
        paused_once = 1'b1;
        sender_pause = 1'b1;
        while (expected_paths.size() > 0 || in_ch.valid) @(posedge clk);
        sender_pause = 1'b0;
      end
    end
    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_paths.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dlp_pkg.sv
rtl/dlp_if.sv
rtl/dlp_graph_store.sv
rtl/dlp_dfs_engine.sv
rtl/dag_longest_path_with_cycle_check.sv
tb/dag_longest_path_with_cycle_check_test.sv
